[rtl/tlpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types, widths and helpers for the threshold-promote list cache.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  // List geometry
  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_BITS  = 16;

  // Field widths fixed by the interface
  localparam int KEY_W       = 64;
  localparam int THR_W       = 16;
  localparam int CAP_W       = 5;
  localparam int FOUND_W     = 4;
  localparam int NEW_COUNT_W = 16;

  // Derived widths
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register map (index taken from the word address)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(3);
  localparam logic [CAP_W-1:0] CAPACITY_RST  = CAP_W'(16);

  // Configuration seen by the list engine
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [CAP_W-1:0] capacity;
  } tlpc_cfg_t;

  // List engine sequencer
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_LOOKUP,
    ENG_UPDATE
  } tlpc_eng_state_e;

  // Clamp the capacity register to 1..MAX_ENTRIES
  function automatic logic [OCC_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    int c;
    c = int'(cap);
    if (c == 0) begin
      c = 1;
    end
    if (c > MAX_ENTRIES) begin
      c = MAX_ENTRIES;
    end
    return OCC_W'(c);
  endfunction

endpackage
`default_nettype wire

[rtl/tlpc_req_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpc_req_queue
// Front end: accepts request items and holds them in a two-entry queue
// until the list engine takes them.
// ----------------------------------------------------------------------------
module tlpc_req_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [tlpc_pkg::KEY_W-1:0] req_key_i,
  output logic                            q_valid_o,
  output logic [tlpc_pkg::KEY_W-1:0]      q_key_o,
  input  wire logic                       q_pop_i
);
  import tlpc_pkg::*;

  logic [KEY_W-1:0] key_mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  // Stall while both slots are taken
  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);

  assign q_valid_o = (count_q != 2'd0);
  assign q_key_o   = key_mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push) begin
      key_mem_q[wr_ptr_q] <= req_key_i;
    end
  end

endmodule
`default_nettype wire

[rtl/tlpc_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpc_list_engine
// Back end: looks a key up in the ordered entry list, updates counts,
// promotes or appends, and presents the result in an output register.
// ----------------------------------------------------------------------------
module tlpc_list_engine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tlpc_pkg::tlpc_cfg_t              cfg_i,
  input  wire logic                             q_valid_i,
  input  wire logic [tlpc_pkg::KEY_W-1:0]       q_key_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  hit_o,
  output logic [tlpc_pkg::FOUND_W-1:0]          found_position_o,
  output logic [tlpc_pkg::NEW_COUNT_W-1:0]      new_count_o,
  output logic                                  promoted_o,
  output logic                                  evicted_o,
  output logic [tlpc_pkg::KEY_W-1:0]            evicted_key_o
);
  import tlpc_pkg::*;

  // Entry list, position 0 is the front
  logic [KEY_W-1:0]      keys_q   [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] counts_q [MAX_ENTRIES];
  logic [OCC_W-1:0]      occ_q, occ_d;

  tlpc_eng_state_e state_q, state_d;

  // Current request and lookup results
  logic [KEY_W-1:0]      key_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      pos_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  full_q;
  logic [IDX_W-1:0]      tail_q;
  logic [OCC_W-1:0]      cap_q;
  logic [KEY_W-1:0]      tail_key_q;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic                   res_hit_q;
  logic [FOUND_W-1:0]     res_pos_q;
  logic [NEW_COUNT_W-1:0] res_cnt_q;
  logic                   res_prom_q;
  logic                   res_evict_q;
  logic [KEY_W-1:0]       res_evkey_q;

  logic [OCC_W-1:0]      cap_eff, len;
  logic [MAX_ENTRIES-1:0] match;
  logic                  lk_hit;
  logic [IDX_W-1:0]      lk_pos;
  logic [IDX_W-1:0]      lk_tail;
  logic                  upd_go, upd_fire, load;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  promote, do_shift;
  logic [IDX_W-1:0]      slot;

  // Compare every live entry against the key
  assign cap_eff = eff_capacity(cfg_i.capacity);
  assign len     = (occ_q < cap_eff) ? occ_q : cap_eff;
  assign lk_tail = IDX_W'(cap_eff - 1'b1);

  always_comb begin
    lk_hit = 1'b0;
    lk_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (keys_q[i] == key_q) && (OCC_W'(i) < len);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        lk_hit = 1'b1;
        lk_pos = IDX_W'(i);
      end
    end
  end

  // Sequencer: pop, look up, update
  assign upd_go   = !out_valid_q || !out_stall_i;
  assign upd_fire = (state_q == ENG_UPDATE) && upd_go;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      ENG_IDLE: begin
        if (q_valid_i) begin
          load    = 1'b1;
          state_d = ENG_LOOKUP;
        end
      end
      ENG_LOOKUP: begin
        state_d = ENG_UPDATE;
      end
      ENG_UPDATE: begin
        if (upd_go) begin
          load    = q_valid_i;
          state_d = q_valid_i ? ENG_LOOKUP : ENG_IDLE;
        end
      end
      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request and the lookup outcome
  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q <= q_key_i;
    end
    if (state_q == ENG_LOOKUP) begin
      hit_q      <= lk_hit;
      pos_q      <= lk_pos;
      cnt_q      <= counts_q[lk_pos];
      full_q     <= (occ_q >= cap_eff);
      tail_q     <= lk_tail;
      cap_q      <= cap_eff;
      tail_key_q <= keys_q[lk_tail];
    end
  end

  // Update decisions
  assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign promote  = CMP_W'(cnt_inc) >= CMP_W'(cfg_i.threshold);
  assign do_shift = hit_q && promote && (pos_q != '0);
  assign slot     = full_q ? tail_q : IDX_W'(occ_q);

  always_comb begin
    occ_d = occ_q;
    if (upd_fire && !hit_q) begin
      occ_d = full_q ? cap_q : occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Apply the hit, promotion or append to the list
  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      if (hit_q && do_shift) begin
        keys_q[0]   <= key_q;
        counts_q[0] <= cnt_inc;
        for (int i = 1; i < MAX_ENTRIES; i++) begin
          if (IDX_W'(i) <= pos_q) begin
            keys_q[i]   <= keys_q[i-1];
            counts_q[i] <= counts_q[i-1];
          end
        end
      end else begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (hit_q) begin
            if (IDX_W'(i) == pos_q) begin
              counts_q[i] <= cnt_inc;
            end
          end else if (IDX_W'(i) == slot) begin
            keys_q[i]   <= key_q;
            counts_q[i] <= COUNT_BITS'(1);
          end
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (upd_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      res_hit_q   <= hit_q;
      res_pos_q   <= hit_q ? FOUND_W'(pos_q) : '0;
      res_cnt_q   <= hit_q ? NEW_COUNT_W'(cnt_inc) : NEW_COUNT_W'(1);
      res_prom_q  <= hit_q && promote;
      res_evict_q <= !hit_q && full_q;
      res_evkey_q <= (!hit_q && full_q) ? tail_key_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = res_hit_q;
  assign found_position_o = res_pos_q;
  assign new_count_o      = res_cnt_q;
  assign promoted_o       = res_prom_q;
  assign evicted_o        = res_evict_q;
  assign evicted_key_o    = res_evkey_q;

endmodule
`default_nettype wire

[rtl/threshold_promote_list_cache.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_promote_list_cache
// Ordered key list with saturating hit counters, threshold promotion to the
// front and tail eviction on misses.
//
// Request channel: in_valid_i / in_stall_o carry one 64-bit req_key_i per
// item into a two-entry queue. Result channel: out_valid_o / out_stall_i
// carry hit, found_position, new_count, promoted, evicted and evicted_key
// from an output register, one result per request.
// Each item passes the list engine's lookup state for the parallel key match,
// then its update state for the count update and list shift. The engine takes
// the next item only as it applies the update of the last one, since that
// lookup/update sequence works on the shared entry list.
// A stalled result holds in the output register; the engine waits with the
// next update, and the queue keeps taking requests until both slots fill.
// Reset empties the list and queue, sets threshold 3 and capacity 16.
// APB registers: 0x0 promote threshold (16 bits), 0x4 capacity (5 bits).
// Write them only while no request is in flight.
// ----------------------------------------------------------------------------
module threshold_promote_list_cache (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [tlpc_pkg::KEY_W-1:0]     req_key_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                hit_o,
  output logic [tlpc_pkg::FOUND_W-1:0]        found_position_o,
  output logic [tlpc_pkg::NEW_COUNT_W-1:0]    new_count_o,
  output logic                                promoted_o,
  output logic                                evicted_o,
  output logic [tlpc_pkg::KEY_W-1:0]          evicted_key_o
);
  import tlpc_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  tlpc_cfg_t        cfg;
  logic             q_valid, q_pop;
  logic [KEY_W-1:0] q_key;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      cap_q <= CAPACITY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
        REG_CAPACITY:  cap_q <= pwdata[CAP_W-1:0];
        default:       thr_q <= thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = 32'(thr_q);
      REG_CAPACITY:  prdata = 32'(cap_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = thr_q;
  assign cfg.capacity  = cap_q;

  // Front end queue
  tlpc_req_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_key_i  (req_key_i),
    .q_valid_o  (q_valid),
    .q_key_o    (q_key),
    .q_pop_i    (q_pop)
  );

  // Back end list engine
  tlpc_list_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_key_i          (q_key),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .found_position_o (found_position_o),
    .new_count_o      (new_count_o),
    .promoted_o       (promoted_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o)
  );

endmodule
`default_nettype wire

[sim/threshold_promote_list_cache_test.sv]
// ----------------------------------------------------------------------------
// threshold_promote_list_cache_test
// Self-checking bench for the threshold-promote list cache. Requests are sent
// with random gaps, results are taken with random stalls, and every result is
// compared field by field with a behavioural list model that is updated at
// each accepted request. Register settings change only while the cache idles.
// ----------------------------------------------------------------------------
module threshold_promote_list_cache_test;
  import tlpc_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WAIT      = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 180;
  localparam int REPEAT_HITS   = 40;

  // Outcome of one lookup
  typedef struct packed {
    logic                   hit;
    logic [FOUND_W-1:0]     position;
    logic [NEW_COUNT_W-1:0] count;
    logic                   promoted;
    logic                   evicted;
    logic [KEY_W-1:0]       victim;
  } lookup_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [2:0]             paddr       = '0;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [KEY_W-1:0]       req_key_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   hit_o;
  logic [FOUND_W-1:0]     found_position_o;
  logic [NEW_COUNT_W-1:0] new_count_o;
  logic                   promoted_o;
  logic                   evicted_o;
  logic [KEY_W-1:0]       evicted_key_o;

  // List model and its settings
  logic [KEY_W-1:0]      list_keys   [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] list_counts [MAX_ENTRIES];
  int                    list_len;
  logic [THR_W-1:0]      cur_threshold;
  logic [CAP_W-1:0]      cur_capacity;

  lookup_result_t pending_lookups [$];
  int  error_count  = 0;
  int  report_lines = 0;
  int  result_index = 0;
  int  stall_left   = 0;
  int  idle_cycles  = 0;
  bit  quiet        = 1'b0;

  threshold_promote_list_cache dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_key_i        (req_key_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .found_position_o (found_position_o),
    .new_count_o      (new_count_o),
    .promoted_o       (promoted_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Look the key up in the list model, update it and return the outcome
  function automatic lookup_result_t lookup_key(input logic [KEY_W-1:0] key);
    lookup_result_t        r;
    int                    limit;
    int                    visible;
    int                    pos;
    int                    i;
    logic [COUNT_BITS-1:0] cnt;
    r     = '0;
    limit = int'(cur_capacity);
    if (limit == 0) begin
      limit = 1;
    end
    if (limit > MAX_ENTRIES) begin
      limit = MAX_ENTRIES;
    end
    // entries beyond the capacity stay invisible
    visible = (list_len < limit) ? list_len : limit;
    pos     = -1;
    for (i = 0; i < visible; i++) begin
      if (pos < 0 && list_keys[i] == key) begin
        pos = i;
      end
    end
    if (pos >= 0) begin
      cnt = list_counts[pos];
      if (cnt != COUNT_MAX) begin
        cnt = cnt + 1'b1;
      end
      list_counts[pos] = cnt;
      r.hit      = 1'b1;
      r.position = FOUND_W'(pos);
      r.count    = NEW_COUNT_W'(cnt);
      r.promoted = (cnt >= cur_threshold);
      // move to the front, shifting the entries ahead of it back
      if (r.promoted) begin
        for (i = pos; i > 0; i--) begin
          list_keys[i]   = list_keys[i-1];
          list_counts[i] = list_counts[i-1];
        end
        list_keys[0]   = key;
        list_counts[0] = cnt;
      end
    end else begin
      // drop the tail entry and everything behind it when full
      if (list_len >= limit) begin
        r.evicted = 1'b1;
        r.victim  = list_keys[limit-1];
        list_len  = limit - 1;
      end
      list_keys[list_len]   = key;
      list_counts[list_len] = 1;
      list_len++;
      r.count = 1;
    end
    return r;
  endfunction

  task automatic report(input string msg);
    error_count++;
    if (report_lines < MAX_REPORTS) begin
      $display("mismatch at result %0d: %s", result_index, msg);
      report_lines++;
    end
  endtask

  // Send one request after a random gap and record its expected outcome
  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_key_i  <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_lookups.push_back(lookup_key(key));
  endtask

  // Hold off until every outstanding result is back, then let the engine settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (index == REG_THRESHOLD) begin
      cur_threshold = value[THR_W-1:0];
    end else begin
      cur_capacity = value[CAP_W-1:0];
    end
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [CAP_W-1:0] cap);
    drain();
    write_register(REG_THRESHOLD, 32'(thr));
    write_register(REG_CAPACITY, 32'(cap));
  endtask

  // Fill the list with reset settings, promote from the tail, evict on a miss
  task automatic test_fill_and_promote();
    logic [KEY_W-1:0] tail_key;
    int               i;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (i == 0) begin
        send_key('0);
      end else if (i == 1) begin
        send_key('1);
      end else begin
        send_key(random_key());
      end
    end
    tail_key = list_keys[MAX_ENTRIES-1];
    send_key(tail_key);
    send_key(tail_key);
    send_key(list_keys[0]);
    send_key(random_key());
  endtask

  // Threshold zero promotes every hit, at the front too
  task automatic test_threshold_zero();
    configure('0, CAP_W'(MAX_ENTRIES));
    send_key(list_keys[7]);
    send_key(list_keys[0]);
  endtask

  // Shrink the capacity below the occupancy, then clamp it at both ends
  task automatic test_capacity_limits();
    configure(THR_W'(3), CAP_W'(2));
    send_key(list_keys[5]);
    configure(THR_W'(3), '0);
    send_key(list_keys[0]);
    send_key(random_key());
    configure(THR_W'(3), '1);
    send_key(random_key());
    send_key(list_keys[0]);
  endtask

  // Hit one key back to back under the highest threshold; it never promotes
  task automatic test_repeat_hits();
    logic [KEY_W-1:0] key;
    int               i;
    configure('1, CAP_W'(MAX_ENTRIES));
    key   = random_key();
    quiet = 1'b1;
    send_key(key);
    for (i = 0; i < REPEAT_HITS; i++) begin
      send_key(key);
    end
    quiet = 1'b0;
  endtask

  // Random requests over a small key pool per setting, with some fresh keys
  task automatic test_random_traffic();
    logic [KEY_W-1:0] pool [MAX_ENTRIES + 4];
    logic [THR_W-1:0] thr;
    logic [CAP_W-1:0] cap;
    int               pool_size;
    int               p;
    int               i;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          thr = THR_W'(1);
          cap = CAP_W'(MAX_ENTRIES);
        end
        1: begin
          thr = THR_W'(2);
          cap = CAP_W'(1);
        end
        2: begin
          thr = '1;
          cap = CAP_W'(4);
        end
        3: begin
          thr = '0;
          cap = '0;
        end
        4: begin
          thr = THR_W'(3);
          cap = '1;
        end
        default: begin
          thr = THR_W'($urandom_range(1, 8));
          cap = CAP_W'($urandom_range(0, 31));
        end
      endcase
      configure(thr, cap);
      pool_size = (cap == 0) ? 3 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES + 2 : int'(cap) + 2);
      for (i = 0; i < pool_size; i++) begin
        pool[i] = random_key();
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 63) == 0) begin
          drain();
        end
        if ($urandom_range(0, 99) < 85) begin
          send_key(pool[$urandom_range(0, pool_size - 1)]);
        end else begin
          send_key(random_key());
        end
      end
      quiet = 1'b0;
    end
  endtask

  // Take results with random stalls and compare against the oldest expectation
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_lookups.pop_front();
        if (hit_o !== want.hit) begin
          report($sformatf("hit %0b, want %0b", hit_o, want.hit));
        end
        if (found_position_o !== want.position) begin
          report($sformatf("found_position %0d, want %0d", found_position_o, want.position));
        end
        if (new_count_o !== want.count) begin
          report($sformatf("new_count %0d, want %0d", new_count_o, want.count));
        end
        if (promoted_o !== want.promoted) begin
          report($sformatf("promoted %0b, want %0b", promoted_o, want.promoted));
        end
        if (evicted_o !== want.evicted) begin
          report($sformatf("evicted %0b, want %0b", evicted_o, want.evicted));
        end
        if (evicted_key_o !== want.victim) begin
          report($sformatf("evicted_key %h, want %h", evicted_key_o, want.victim));
        end
      end
      result_index++;
      stall_left = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    list_len      = 0;
    cur_threshold = THRESHOLD_RST;
    cur_capacity  = CAPACITY_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_promote();
    test_threshold_zero();
    test_capacity_limits();
    test_repeat_hits();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
